>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Expression must never become true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("assertion failed");

`endif

>>> rtl/kscl_pkg.sv
// ----------------------------------------------------------------------------
// kscl_pkg
// Shared constants, types and the key decoder of the keypad code lock.
// ----------------------------------------------------------------------------
package kscl_pkg;

	// Register map
	localparam int          CFG_IDX_W        = 1;
	localparam logic [0:0]  CFG_SCAN_PERIOD  = 1'd0;
	localparam logic [0:0]  CFG_CODE_DIGITS  = 1'd1;

	// Field widths
	localparam int COL_W    = 4;
	localparam int MAP_W    = 16;
	localparam int KEY_W    = 4;
	localparam int DRIVE_W  = 3;
	localparam int PERIOD_W = 16;
	localparam int DIGIT_W  = 4;
	localparam int CODE_MAX = 11;
	localparam int CODE_W   = CODE_MAX * DIGIT_W;

	// Code length and entry position range
	localparam int CODE_LENGTH = 11;
	localparam int POS_W       = 4;

	// Default register values and row count
	localparam int                 ROW_COUNT_DEF   = 4;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd100;
	localparam logic [CODE_W-1:0]   CODE_RESET     = 44'd6734513980198;
	localparam logic [DRIVE_W-1:0]  DRIVE_NONE     = 3'd4;

	// Key codes
	localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd10;
	localparam logic [KEY_W-1:0] KEY_BACK  = 4'd11;
	localparam logic [KEY_W-1:0] KEY_OK    = 4'd12;
	localparam logic [KEY_W-1:0] KEY_NONE  = 4'd13;

	// Key for each map bit (column + 4 * row)
	localparam logic [KEY_W-1:0] BIT_TO_KEY [MAP_W] = '{
		4'd7, 4'd8, 4'd9, 4'd10, 4'd4, 4'd5, 4'd6, 4'd11,
		4'd1, 4'd2, 4'd3, 4'd13, 4'd0, 4'd13, 4'd13, 4'd12
	};

	// Request from the scanner to the lock sequencer
	typedef struct packed {
		logic             step;
		logic             press;
		logic [KEY_W-1:0] key;
	} lock_req_t;

	// Lock sequencer status
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             open;
	} lock_stat_t;

	// Map to key code: only a single pressed key decodes
	function automatic logic [KEY_W-1:0] decode_key(input logic [MAP_W-1:0] map);
		logic [KEY_W-1:0] k;
		k = KEY_NONE;
		for (int b = 0; b < MAP_W; b++) begin
			if (map == (MAP_W'(1) << b))
				k = BIT_TO_KEY[b[3:0]];
		end
		return k;
	endfunction

endpackage

>>> rtl/kscl_lock.sv
// ----------------------------------------------------------------------------
// kscl_lock
// Code entry sequencer: digit check, clear, backspace, ok and lockout.
// ----------------------------------------------------------------------------
module kscl_lock (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kscl_pkg::lock_req_t                 req,
	input  logic [kscl_pkg::CODE_W-1:0]         code_digits,
	output kscl_pkg::lock_stat_t                stat
);

	localparam int PW = kscl_pkg::POS_W;
	localparam int KW = kscl_pkg::KEY_W;

	logic [PW-1:0] pos_q;
	logic          open_q;
	logic [PW-1:0] pos_d;
	logic          open_d;
	logic [PW-1:0] idx;
	logic [KW-1:0] digit;
	logic [kscl_pkg::CODE_W-1:0] shifted;

	// Pick the expected digit; indexes past the stored code read as zero
	assign idx     = pos_q - PW'(1);
	assign shifted = code_digits >> {idx, 2'b00};
	assign digit   = shifted[KW-1:0];

	// Next position on a new press
	always_comb begin
		pos_d  = pos_q;
		open_d = open_q;
		if (req.press) begin
			if (pos_q == '0) begin
				if (req.key == kscl_pkg::KEY_CLEAR)
					pos_d = PW'(1);
			end else if (pos_q <= PW'(kscl_pkg::CODE_LENGTH) &&
			             req.key < kscl_pkg::KEY_NONE && req.key == digit) begin
				pos_d = pos_q + PW'(1);
			end else if (req.key == kscl_pkg::KEY_CLEAR) begin
				pos_d = PW'(1);
			end else if (req.key == kscl_pkg::KEY_BACK) begin
				pos_d = (pos_q > PW'(1)) ? pos_q - PW'(1) : PW'(1);
			end else if (req.key == kscl_pkg::KEY_OK) begin
				if (pos_q == PW'(kscl_pkg::CODE_LENGTH + 1))
					open_d = 1'b1;
				pos_d = PW'(1);
			end else begin
				pos_d = '0;
			end
		end
	end

	// Advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PW'(1);
			open_q <= 1'b0;
		end else if (req.step) begin
			pos_q  <= pos_d;
			open_q <= open_d;
		end
	end

	assign stat.position = pos_q;
	assign stat.open     = open_q;

endmodule

>>> rtl/keypad_scan_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_scan_code_lock
// Keypad matrix row scanner feeding a code entry lock.
// ----------------------------------------------------------------------------
// One tick beat is accepted per clock cycle while the sink does not stall. A
// beat lands in an input register; when the result register is free or being
// drained, the tick counter, row scan, key decode and lock sequencer update
// together and the result beat appears, so the sustained rate is one beat per
// cycle, set only by the single state-update stage. The result register holds
// the beat while the sink stalls and the input register still takes one more.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_scan_code_lock #(
	parameter int ROW_COUNT = kscl_pkg::ROW_COUNT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [kscl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kscl_pkg::CODE_W-1:0]            cfg_data,
	// tick input
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [kscl_pkg::COL_W-1:0]             column_levels,
	// result
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [kscl_pkg::DRIVE_W-1:0]           drive_row,
	output logic [kscl_pkg::MAP_W-1:0]             key_map,
	output logic [kscl_pkg::KEY_W-1:0]             key_code,
	output logic [kscl_pkg::POS_W-1:0]             entry_position,
	output logic                                   unlocked
);

	localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int DW = kscl_pkg::DRIVE_W;
	localparam int MW = kscl_pkg::MAP_W;
	localparam int CW = kscl_pkg::COL_W;
	localparam int TW = kscl_pkg::PERIOD_W;

	// Configuration registers
	logic [TW-1:0]                 scan_period_q;
	logic [kscl_pkg::CODE_W-1:0]   code_digits_q;

	// Pipeline and state
	logic          valid_s1;
	logic [CW-1:0] cols_s1;
	logic          out_valid_q;
	logic          advance;
	logic [TW-1:0] tick_q;
	logic [RW-1:0] row_q;
	logic          started_q;
	logic [MW-1:0] map_q;
	logic [kscl_pkg::KEY_W-1:0] key_q;

	logic [TW-1:0] tick_inc;
	logic          scan;
	logic [MW-1:0] map_d;
	logic [RW-1:0] row_d;
	logic [kscl_pkg::KEY_W-1:0] key_d;

	kscl_pkg::lock_req_t  lock_req;
	kscl_pkg::lock_stat_t lock_stat;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= kscl_pkg::PERIOD_RESET;
			code_digits_q <= kscl_pkg::CODE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kscl_pkg::CFG_SCAN_PERIOD: scan_period_q <= cfg_data[TW-1:0];
				kscl_pkg::CFG_CODE_DIGITS: code_digits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: advance when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Hold the tick beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			cols_s1 <= column_levels;
	end

	// Tick counter and scan strobe
	assign tick_inc = tick_q + TW'(1);
	assign scan     = (tick_inc >= scan_period_q) || (tick_inc == '0);
	assign row_d    = (row_q == RW'(ROW_COUNT - 1)) ? '0 : row_q + RW'(1);

	// Latch the current row's columns; rows past the map are dropped
	always_comb begin
		map_d = map_q;
		if (scan) begin
			for (int r = 0; r < MW / CW; r++) begin
				if (r < ROW_COUNT && int'(row_q) == r)
					map_d[r*CW +: CW] = ~cols_s1;
			end
		end
	end

	assign key_d = kscl_pkg::decode_key(map_d);

	// A changed nonzero map is a new press
	assign lock_req.step  = advance;
	assign lock_req.press = (map_d != '0) && (map_d != map_q);
	assign lock_req.key   = key_d;

	kscl_lock u_lock (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (lock_req),
		.code_digits (code_digits_q),
		.stat        (lock_stat)
	);

	// Advance scanner state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			row_q     <= '0;
			started_q <= 1'b0;
			map_q     <= '0;
			key_q     <= kscl_pkg::KEY_NONE;
		end else if (advance) begin
			tick_q <= scan ? '0 : tick_inc;
			if (scan) begin
				row_q     <= row_d;
				started_q <= 1'b1;
			end
			map_q <= map_d;
			key_q <= key_d;
		end
	end

	// Result beat straight from the state registers
	assign out_valid      = out_valid_q;
	assign drive_row      = started_q ? DW'(row_q) : kscl_pkg::DRIVE_NONE;
	assign key_map        = map_q;
	assign key_code       = key_q;
	assign entry_position = lock_stat.position;
	assign unlocked       = lock_stat.open;

	// Checks
	`ASSERT_NEVER(a_unlock_sticky, clk, arst_n, $fell(lock_stat.open))
	`ASSERT_ALWAYS(a_pos_range, clk, arst_n,
		lock_stat.position <= kscl_pkg::POS_W'(kscl_pkg::CODE_LENGTH + 1))
	`ASSERT_IMPLY(a_key_single, clk, arst_n, key_q != kscl_pkg::KEY_NONE, $onehot(map_q))
	`ASSERT_IMPLY(a_no_scan_no_map, clk, arst_n, !started_q, map_q == '0)

endmodule

>>> dv/kscl_tick_checker.sv
// ----------------------------------------------------------------------------
// kscl_tick_checker
// Watches the configuration, tick and result channels of the keypad code
// lock, predicts each result beat from the accepted tick beats and compares
// it field by field. Hands the mismatch count and the number of results
// still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module kscl_tick_checker
	import kscl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [COL_W-1:0]     column_levels,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DRIVE_W-1:0]   drive_row,
	input  logic [MAP_W-1:0]     key_map,
	input  logic [KEY_W-1:0]     key_code,
	input  logic [POS_W-1:0]     entry_position,
	input  logic                 unlocked,
	output int                   fails,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [POS_W-1:0] POS_LOCKOUT = 4'd0;
	localparam logic [POS_W-1:0] POS_FIRST   = 4'd1;
	localparam logic [POS_W-1:0] POS_READY   = POS_W'(CODE_LENGTH + 1);

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic [MAP_W-1:0]   map;
		logic [KEY_W-1:0]   key;
		logic [POS_W-1:0]   pos;
		logic               open;
	} tick_result_t;

	// predicted block state and register copies
	logic [PERIOD_W-1:0] tick_cnt;
	logic [1:0]          row_sel;
	logic                row_live;
	logic [MAP_W-1:0]    held_map;
	logic [MAP_W-1:0]    last_map;
	logic [POS_W-1:0]    entry_pos;
	logic                is_open;
	logic [PERIOD_W-1:0] period_cfg;
	logic [CODE_W-1:0]   code_cfg;

	tick_result_t due_results[$];
	tick_result_t want;
	tick_result_t seen;
	tick_result_t next_res;
	int           checked;

	initial fails = 0;

	// key printed on the keypad at each map bit
	function automatic logic [KEY_W-1:0] key_at(input int b);
		case (b)
			0: return 4'd7;
			1: return 4'd8;
			2: return 4'd9;
			3: return KEY_CLEAR;
			4: return 4'd4;
			5: return 4'd5;
			6: return 4'd6;
			7: return KEY_BACK;
			8: return 4'd1;
			9: return 4'd2;
			10: return 4'd3;
			12: return 4'd0;
			15: return KEY_OK;
			default: return KEY_NONE;
		endcase
	endfunction

	// decode only a map with exactly one key down
	function automatic logic [KEY_W-1:0] map_key(input logic [MAP_W-1:0] m);
		logic [KEY_W-1:0] k;
		k = KEY_NONE;
		if ($countones(m) == 1) begin
			for (int b = 0; b < MAP_W; b++) begin
				if (m[b])
					k = key_at(b);
			end
		end
		return k;
	endfunction

	// advance the code entry on a fresh press
	task automatic step_entry(input logic [KEY_W-1:0] k);
		logic [POS_W-1:0]   p;
		logic [DIGIT_W-1:0] digit;
		p = entry_pos;
		digit = '0;
		if (p == POS_LOCKOUT) begin
			if (k == KEY_CLEAR)
				entry_pos = POS_FIRST;
		end else begin
			if (p <= CODE_LENGTH)
				digit = code_cfg[DIGIT_W * (int'(p) - 1) +: DIGIT_W];
			if (p <= CODE_LENGTH && k != KEY_NONE && k == digit)
				entry_pos = p + 1'b1;
			else if (k == KEY_CLEAR)
				entry_pos = POS_FIRST;
			else if (k == KEY_BACK)
				entry_pos = (p > POS_FIRST) ? p - 1'b1 : POS_FIRST;
			else if (k == KEY_OK) begin
				if (p == POS_READY)
					is_open = 1'b1;
				entry_pos = POS_FIRST;
			end else
				entry_pos = POS_LOCKOUT;
		end
	endtask

	// one tick: count, maybe scan a row, decode and sequence
	task automatic predict_tick(input logic [COL_W-1:0] cols, output tick_result_t r);
		logic [KEY_W-1:0] k;
		k = KEY_NONE;
		tick_cnt = tick_cnt + 1'b1;
		if (tick_cnt >= period_cfg || tick_cnt == '0) begin
			tick_cnt = '0;
			for (int i = 0; i < COL_W; i++)
				held_map[i + 4 * int'(row_sel)] = ~cols[i];
			row_sel = row_sel + 1'b1;
			row_live = 1'b1;
		end
		k = map_key(held_map);
		if (held_map != '0 && held_map != last_map)
			step_entry(k);
		last_map = held_map;
		r.drive = row_live ? {1'b0, row_sel} : DRIVE_NONE;
		r.map = held_map;
		r.key = k;
		r.pos = entry_pos;
		r.open = is_open;
	endtask

	task automatic report_mismatch(input string what, input logic [MAP_W-1:0] exp_v,
			input logic [MAP_W-1:0] got_v);
		if (fails < 40)
			$display("[%0t] result beat %0d %s: expected %0h, got %0h",
				$time, checked, what, exp_v, got_v);
		fails++;
	endtask

	// compare results first, then take config and tick beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt = '0;
			row_sel = '0;
			row_live = 1'b0;
			held_map = '0;
			last_map = '0;
			entry_pos = POS_FIRST;
			is_open = 1'b0;
			period_cfg = PERIOD_RESET;
			code_cfg = CODE_RESET;
			due_results.delete();
			checked = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {drive_row, key_map, key_code, entry_position, unlocked};
				if (due_results.size() == 0) begin
					report_mismatch("result with no tick pending", '0, seen.map);
				end else begin
					want = due_results.pop_front();
					if (seen.drive !== want.drive)
						report_mismatch("drive_row", want.drive, seen.drive);
					if (seen.map !== want.map)
						report_mismatch("key_map", want.map, seen.map);
					if (seen.key !== want.key)
						report_mismatch("key_code", want.key, seen.key);
					if (seen.pos !== want.pos)
						report_mismatch("entry_position", want.pos, seen.pos);
					if (seen.open !== want.open)
						report_mismatch("unlocked", want.open, seen.open);
				end
				checked++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SCAN_PERIOD)
					period_cfg = cfg_data[PERIOD_W-1:0];
				else if (cfg_index == CFG_CODE_DIGITS)
					code_cfg = cfg_data;
			end
			if (in_valid && in_ready) begin
				predict_tick(column_levels, next_res);
				due_results.push_back(next_res);
			end
			pending <= due_results.size();
		end
	end

endmodule

>>> dv/keypad_scan_code_lock_tb.sv
// ----------------------------------------------------------------------------
// keypad_scan_code_lock_tb
// Drives tick beats into the keypad code lock and gives the verdict.
// ----------------------------------------------------------------------------
// The stimulus follows the scan schedule, so a key press shows up as the
// one low column exactly when its row is latched. Most of the traffic is
// whole code entries (clear, the digits, ok) with backspaces and wrong keys
// mixed in; the rest is loose presses and raw column noise. Phases change
// the scan period, the code and the idling on both channels, and one
// phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module keypad_scan_code_lock_tb;
	import kscl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SCAN_PERIOD;
	logic [CODE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [COL_W-1:0]     column_levels = 4'hF;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DRIVE_W-1:0]   drive_row;
	logic [MAP_W-1:0]     key_map;
	logic [KEY_W-1:0]     key_code;
	logic [POS_W-1:0]     entry_position;
	logic                 unlocked;

	int fails;
	int pending;

	// scan schedule as seen from the tick side
	logic [PERIOD_W-1:0] trk_tick = '0;
	logic [1:0]          trk_row = '0;
	logic [PERIOD_W-1:0] trk_period = PERIOD_RESET;
	logic [CODE_W-1:0]   lock_code = CODE_RESET;
	int                  scans_seen = 0;
	int                  beats = 0;

	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_req = 1'b0;

	keypad_scan_code_lock uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.column_levels  (column_levels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_row      (drive_row),
		.key_map        (key_map),
		.key_code       (key_code),
		.entry_position (entry_position),
		.unlocked       (unlocked)
	);

	kscl_tick_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.column_levels  (column_levels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_row      (drive_row),
		.key_map        (key_map),
		.key_code       (key_code),
		.entry_position (entry_position),
		.unlocked       (unlocked),
		.fails          (fails),
		.pending        (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("keypad_scan_code_lock test failed");
		$finish;
	end

	// next accepted beat latches a row
	function automatic logic scan_due();
		logic [PERIOD_W-1:0] nxt;
		nxt = trk_tick + 1'b1;
		return (nxt >= trk_period) || (nxt == '0);
	endfunction

	function automatic int bit_for_key(input logic [KEY_W-1:0] k);
		case (k)
			4'd0: return 12;
			4'd1: return 8;
			4'd2: return 9;
			4'd3: return 10;
			4'd4: return 4;
			4'd5: return 5;
			4'd6: return 6;
			4'd7: return 0;
			4'd8: return 1;
			4'd9: return 2;
			KEY_CLEAR: return 3;
			KEY_BACK: return 7;
			KEY_OK: return 15;
			default: begin
				// no key on these positions
				case ($urandom_range(2))
					0: return 11;
					1: return 13;
					default: return 14;
				endcase
			end
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] random_code(input int top_digit);
		logic [CODE_W-1:0] c;
		c = '0;
		for (int i = 0; i < CODE_MAX; i++)
			c[DIGIT_W * i +: DIGIT_W] = DIGIT_W'($urandom_range(top_digit, 0));
		return c;
	endfunction

	// offer one tick beat, hold it until accepted, then track the scan
	task automatic send_tick(input logic [COL_W-1:0] cols);
		int gap;
		gap = 0;
		while (gap < 8 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		column_levels <= cols;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		if (scan_due()) begin
			trk_tick = '0;
			trk_row = trk_row + 1'b1;
			scans_seen++;
		end else begin
			trk_tick = trk_tick + 1'b1;
		end
		beats++;
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SCAN_PERIOD)
			trk_period = val[PERIOD_W-1:0];
		else
			lock_code = val;
		@(posedge clk);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	// run all rows through with nothing pressed
	task automatic release_all();
		int start;
		start = scans_seen;
		while (scans_seen - start < 4)
			send_tick(4'hF);
	endtask

	// press one key for a single latch of its row, then release it
	task automatic press_key(input logic [KEY_W-1:0] k);
		int         b;
		logic [1:0] r;
		logic [3:0] lows;
		b = bit_for_key(k);
		r = 2'(b / 4);
		lows = ~(4'b0001 << (b % 4));
		while (!(scan_due() && trk_row == r))
			send_tick(4'hF);
		send_tick(lows);
		while (!(scan_due() && trk_row == r))
			send_tick(4'hF);
		send_tick(4'hF);
	endtask

	// one burst of keypad activity
	task automatic key_round();
		int               pick;
		int               slip;
		int               n;
		logic [KEY_W-1:0] d;
		pick = $urandom_range(99);
		if (pick < 55) begin
			// full code entry with the odd slip or correction
			press_key(KEY_CLEAR);
			slip = ($urandom_range(99) < 15) ? int'($urandom_range(CODE_LENGTH - 1)) : -1;
			for (int i = 0; i < CODE_LENGTH; i++) begin
				d = lock_code[DIGIT_W * i +: DIGIT_W];
				if (i == slip)
					press_key(KEY_W'($urandom_range(12)));
				press_key(d);
				if ($urandom_range(99) < 8) begin
					press_key(KEY_BACK);
					press_key(d);
				end
			end
			press_key(($urandom_range(99) < 90) ? KEY_OK : KEY_W'($urandom_range(12)));
		end else if (pick < 85) begin
			n = $urandom_range(4, 1);
			repeat (n) press_key(KEY_W'($urandom_range(13)));
		end else begin
			n = $urandom_range(6, 1);
			repeat (n) send_tick(COL_W'($urandom_range(15)));
			release_all();
		end
	endtask

	task automatic run_phase(input logic [PERIOD_W-1:0] period, input logic [CODE_W-1:0] code,
			input int idle, input int stall, input logic hold, input int quota);
		int start;
		settle();
		write_cfg(CFG_SCAN_PERIOD, CODE_W'(period));
		write_cfg(CFG_CODE_DIGITS, code);
		idle_pct = idle;
		stall_pct = stall;
		if (hold)
			hold_req = 1'b1;
		start = beats;
		while (beats - start < quota)
			key_round();
	endtask

	initial begin
		logic [CODE_W-1:0] ctl_code;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no row is latched within the first few ticks
		repeat (3) send_tick(4'h0);

		// scan every tick, code of all zeros
		settle();
		write_cfg(CFG_SCAN_PERIOD, '0);
		write_cfg(CFG_CODE_DIGITS, '0);
		repeat (4) send_tick(4'h0);
		send_tick(4'hE);
		send_tick(4'hD);
		send_tick(4'hB);
		send_tick(4'h7);
		release_all();
		press_key(KEY_CLEAR);
		press_key(KEY_BACK);
		press_key(KEY_OK);
		press_key(4'd0);
		press_key(KEY_NONE);
		press_key(KEY_CLEAR);

		// random phases, one per idling mode
		run_phase(16'd1, random_code(9), 0, 0, 1'b0, 200);
		ctl_code = random_code(9);
		ctl_code[DIGIT_W * 3 +: DIGIT_W] = KEY_CLEAR;
		ctl_code[DIGIT_W * 5 +: DIGIT_W] = KEY_BACK;
		ctl_code[DIGIT_W * 8 +: DIGIT_W] = KEY_OK;
		run_phase(16'd0, ctl_code, 50, 0, 1'b0, 200);
		run_phase(16'd2, CODE_RESET, 0, 50, 1'b1, 200);
		run_phase(PERIOD_W'($urandom_range(3)), random_code(15), 35, 35, 1'b0, 200);

		// longest period, all-ones code: ticks only count
		settle();
		write_cfg(CFG_SCAN_PERIOD, CODE_W'(16'hFFFF));
		write_cfg(CFG_CODE_DIGITS, {CODE_W{1'b1}});
		repeat (12) send_tick(COL_W'($urandom_range(15)));

		settle();
		repeat (3) @(posedge clk);
		if (fails == 0)
			$display("keypad_scan_code_lock test passed");
		else
			$display("keypad_scan_code_lock test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/kscl_pkg.sv
rtl/kscl_lock.sv
rtl/keypad_scan_code_lock.sv
dv/kscl_tick_checker.sv
dv/keypad_scan_code_lock_tb.sv
